@@ sv/isi_pkg.sv @@
`timescale 1ns / 1ps

package isi_pkg;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_BRACKET = 2'd1,
        STAT_FULL       = 2'd2,
        STAT_RSVD       = 2'd3
    } status_t;

    localparam int TIME_W    = 48;
    localparam int QUAT_W    = 64;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 48;
    localparam int DIV_QBITS = 34;

    // 0.9995 in Q2.28, truncated.
    localparam logic [33:0] DOT_LIMIT = 34'd268301238;

    typedef struct packed {
        logic                 start;
        logic                 round;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    function automatic logic signed [15:0] clamp_q14(input logic signed [34:0] v);
        logic signed [15:0] r;
        if (v > 35'sd16384) begin
            r = 16'sd16384;
        end
        else if (v < -35'sd16384) begin
            r = -16'sd16384;
        end
        else begin
            r = 16'(v);
        end
        return r;
    endfunction

endpackage

@@ sv/isi_in_if.sv @@
`timescale 1ns / 1ps

interface isi_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [7:0]         src_id;
    logic [47:0]        time_us;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [63:0]        quat_packed;

    modport source (
        output valid, action, src_id, time_us, accel_x, accel_y, accel_z,
               gyro_x, gyro_y, gyro_z, quat_packed,
        input  ready
    );
    modport sink (
        input  valid, action, src_id, time_us, accel_x, accel_y, accel_z,
               gyro_x, gyro_y, gyro_z, quat_packed,
        output ready
    );
endinterface

@@ sv/isi_out_if.sv @@
`timescale 1ns / 1ps

interface isi_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [15:0] out_accel_x;
    logic signed [15:0] out_accel_y;
    logic signed [15:0] out_accel_z;
    logic signed [15:0] out_gyro_x;
    logic signed [15:0] out_gyro_y;
    logic signed [15:0] out_gyro_z;
    logic signed [15:0] out_quat_w;
    logic signed [15:0] out_quat_x;
    logic signed [15:0] out_quat_y;
    logic signed [15:0] out_quat_z;

    modport source (
        output valid, status, out_accel_x, out_accel_y, out_accel_z,
               out_gyro_x, out_gyro_y, out_gyro_z,
               out_quat_w, out_quat_x, out_quat_y, out_quat_z,
        input  ready
    );
    modport sink (
        input  valid, status, out_accel_x, out_accel_y, out_accel_z,
               out_gyro_x, out_gyro_y, out_gyro_z,
               out_quat_w, out_quat_x, out_quat_y, out_quat_z,
        output ready
    );
endinterface

@@ sv/isi_window_mem.sv @@
`timescale 1ns / 1ps

module isi_window_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 272
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ sv/isi_div.sv @@
`timescale 1ns / 1ps

module isi_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  isi_pkg::div_req_t                 req,
    output logic                              done,
    output logic [isi_pkg::DIV_QBITS-1:0]     quot
);
    import isi_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_QBITS-1:0] low_reg;
    logic [5:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_NUM_W-1:0] nsum;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    always_comb
    begin
        nsum  = req.num + (req.round ? DIV_NUM_W'(req.den >> 1) : '0);
        trial = {rem_reg, low_reg[DIV_QBITS-1]};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            low_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= DIV_DEN_W'(nsum >> DIV_QBITS);
                low_reg  <= nsum[DIV_QBITS-1:0];
                den_reg  <= req.den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
                low_reg <= {low_reg[DIV_QBITS-2:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_QBITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = low_reg;
endmodule

@@ sv/isi_isqrt.sv @@
`timescale 1ns / 1ps

module isi_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] b_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] rb;

    assign rb = r_reg + b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            r_reg    <= '0;
            b_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                v_reg    <= radicand;
                r_reg    <= '0;
                b_reg    <= 64'd1 << 62;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (v_reg >= rb)
                begin
                    v_reg <= v_reg - rb;
                    r_reg <= (r_reg >> 1) + b_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                b_reg <= b_reg >> 2;
                if (b_reg[0])
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];
endmodule

@@ sv/imu_sample_slerp_interpolator.sv @@
`timescale 1ns / 1ps

// Channel  Modport        Carries
// req      isi_in_if.sink    action, src_id, time_us, accel, gyro, quat_packed
// rsp      isi_out_if.source status, interpolated accel, gyro and quaternion
//
// Append, clear and no-op items go from idle straight to the done state.
// A query scans the window at one entry per cycle, then runs the shared divider
// and the square-root unit, on either the nlerp path or the slerp path.
// Reset is asynchronous and active low; it empties the window at once.
// A result waiting on rsp does not stop req from accepting the next
// transaction, but that transaction then waits in ST_DONE until rsp is free.

module imu_sample_slerp_interpolator #(
    parameter int WINDOW_DEPTH = 256,
    parameter int SAMPLE_BITS  = 16,
    parameter int SOURCE_BITS  = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    isi_in_if.sink    req,
    isi_out_if.source rsp
);
    import isi_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int AW      = $clog2(WINDOW_DEPTH);
    localparam int CW      = $clog2(WINDOW_DEPTH + 1);
    localparam int SEXTW   = (SB > 16) ? SB : 16;
    localparam int SRCEXT  = (SOURCE_BITS > 8) ? SOURCE_BITS : 8;
    localparam int OW      = (SB < 16) ? SB : 16;
    localparam int LW      = SEXTW + 2;
    localparam int SMP_LO  = QUAT_W;
    localparam int SRC_LO  = SMP_LO + 6 * SB;
    localparam int TIM_LO  = SRC_LO + SOURCE_BITS;
    localparam int ENTRY_W = TIM_LO + TIME_W;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_SCAN  = 12'b000000000010,
        ST_TDIV  = 12'b000000000100,
        ST_LERP  = 12'b000000001000,
        ST_DOT   = 12'b000000010000,
        ST_FLIP  = 12'b000000100000,
        ST_SQ    = 12'b000001000000,
        ST_ROOT  = 12'b000010000000,
        ST_NDIV  = 12'b000100000000,
        ST_NEXT  = 12'b001000000000,
        ST_FINAL = 12'b010000000000,
        ST_DONE  = 12'b100000000000
    } state_t;

    typedef enum logic [3:0] {
        PH_NLERP  = 4'b0001,
        PH_UNIT_P = 4'b0010,
        PH_UNIT_N = 4'b0100,
        PH_BISECT = 4'b1000
    } phase_t;

    state_t               state_reg;
    phase_t               phase_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        k_reg;
    logic                 pend_reg;
    logic                 go_reg;
    logic                 hp_reg;
    logic                 hn_reg;
    logic [3:0]           lane_reg;
    logic [3:0]           bit_reg;
    status_t              status_reg;
    logic [SOURCE_BITS-1:0] src_reg;
    logic [TIME_W-1:0]    tm_reg;
    logic [TIME_W-1:0]    tp_reg;
    logic [TIME_W-1:0]    tn_reg;
    logic [ENTRY_W-1:0]   prev_reg;
    logic [ENTRY_W-1:0]   next_reg;
    logic [15:0]          t_reg;
    logic signed [15:0]   p_reg [4];
    logic signed [16:0]   n_reg [4];
    logic signed [16:0]   r_reg [4];
    logic signed [31:0]   a_reg [4];
    logic signed [31:0]   b_reg [4];
    logic signed [33:0]   dot_reg;
    logic [63:0]          s_reg;
    logic [31:0]          len_reg;
    logic [15:0]          smp_out_reg [6];
    logic signed [15:0]   q_out_reg [4];
    logic                 rsp_valid_reg;
    status_t              rsp_status_reg;
    logic [15:0]          rsp_smp_reg [6];
    logic signed [15:0]   rsp_q_reg [4];

    logic                 accept;
    logic                 full;
    logic                 wr_en;
    logic [ENTRY_W-1:0]   wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [ENTRY_W-1:0]   rd_data;
    logic [15:0]          field_in [6];
    logic [SEXTW-1:0]     smp_ext [6];
    logic [SRCEXT-1:0]    src_ext;
    logic [TIME_W-1:0]    rd_time;
    logic [SOURCE_BITS-1:0] rd_src;

    logic [3:0]           lane_off;
    logic [1:0]           qlane;
    logic signed [LW-1:0] lp;
    logic signed [LW-1:0] ln;
    logic signed [LW:0]   ldiff;
    logic signed [LW+17:0] lprod;
    logic signed [LW+17:0] lsh;
    logic signed [LW+1:0] lres;

    logic [1:0]           vlane;
    logic signed [32:0]   vsel;
    logic [31:0]          vabs;
    logic [63:0]          vsq;
    logic [63:0]          nshift;
    logic signed [33:0]   dprod;
    logic signed [33:0]   absdot;

    div_req_t             dreq;
    logic                 div_done;
    logic [DIV_QBITS-1:0] div_quot;
    logic signed [34:0]   qs;
    logic                 sq_start;
    logic [63:0]          sq_in;
    logic                 sq_done;
    logic [31:0]          sq_root;
    logic signed [15:0]   fin_q [4];

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign full      = (count_reg == CW'(WINDOW_DEPTH));

    always_comb
    begin
        field_in[0] = $unsigned(req.accel_x);
        field_in[1] = $unsigned(req.accel_y);
        field_in[2] = $unsigned(req.accel_z);
        field_in[3] = $unsigned(req.gyro_x);
        field_in[4] = $unsigned(req.gyro_y);
        field_in[5] = $unsigned(req.gyro_z);
        src_ext     = SRCEXT'(req.src_id);
        wr_data     = '0;
        wr_data[0 +: QUAT_W] = req.quat_packed;
        for (int i = 0; i < 6; i++)
        begin
            smp_ext[i] = SEXTW'(field_in[i]);
            wr_data[SMP_LO + i * SB +: SB] = smp_ext[i][SB-1:0];
        end
        wr_data[SRC_LO +: SOURCE_BITS] = src_ext[SOURCE_BITS-1:0];
        wr_data[TIM_LO +: TIME_W]      = req.time_us;
        wr_en   = accept && (req.action == ACT_APPEND) && !full;
        rd_en   = (state_reg == ST_SCAN) && (k_reg < count_reg);
        rd_addr = k_reg[AW-1:0];
        rd_time = rd_data[TIM_LO +: TIME_W];
        rd_src  = rd_data[SRC_LO +: SOURCE_BITS];
    end

    isi_window_mem #(
        .DEPTH (WINDOW_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared lerp lane: six sample lanes, then four quaternion lanes.
    always_comb
    begin
        lane_off = lane_reg - 4'd6;
        qlane    = lane_off[1:0];
        if (lane_reg < 4'd6)
        begin
            lp = LW'($signed(prev_reg[SMP_LO + int'(lane_reg) * SB +: SB]));
            ln = LW'($signed(next_reg[SMP_LO + int'(lane_reg) * SB +: SB]));
        end
        else
        begin
            lp = LW'(p_reg[qlane]);
            ln = LW'(n_reg[qlane]);
        end
        ldiff = (LW+1)'(ln) - (LW+1)'(lp);
        lprod = (LW+18)'(ldiff) * (LW+18)'($signed({1'b0, t_reg}));
        lsh   = (lprod + (LW+18)'(32768)) >>> 16;
        lres  = (LW+2)'(lp) + (LW+2)'(lsh);
    end

    always_comb
    begin
        vlane = lane_reg[1:0];
        case (phase_reg)
            PH_NLERP:  vsel = 33'(r_reg[vlane]);
            PH_UNIT_P: vsel = 33'(p_reg[vlane]);
            PH_UNIT_N: vsel = 33'(n_reg[vlane]);
            PH_BISECT: vsel = 33'(a_reg[vlane]) + 33'(b_reg[vlane]);
            default:   vsel = '0;
        endcase
        vabs = vsel[32] ? 32'(-vsel) : 32'(vsel);
        vsq  = 64'(vabs) * 64'(vabs);
        case (phase_reg)
            PH_NLERP:  nshift = 64'(vabs) << 28;
            PH_BISECT: nshift = 64'(vabs) << 30;
            default:   nshift = 64'(vabs) << 44;
        endcase
        sq_in    = (phase_reg == PH_BISECT) ? s_reg : (s_reg << 28);
        sq_start = (state_reg == ST_ROOT) && !go_reg;
        dprod    = 34'(p_reg[vlane]) * 34'(n_reg[vlane]);
        absdot   = dot_reg[33] ? -dot_reg : dot_reg;
        qs       = vsel[32] ? -35'(div_quot) : 35'(div_quot);
        if (state_reg == ST_TDIV)
        begin
            dreq.start = !go_reg;
            dreq.round = 1'b0;
            dreq.num   = {tm_reg - tp_reg, 16'h0000};
            dreq.den   = tn_reg - tp_reg;
        end
        else
        begin
            dreq.start = (state_reg == ST_NDIV) && !go_reg;
            dreq.round = 1'b1;
            dreq.num   = nshift;
            dreq.den   = DIV_DEN_W'(len_reg);
        end
        for (int i = 0; i < 4; i++)
        begin
            fin_q[i] = clamp_q14(a_reg[i][31]
                ? -35'((33'(32'(-a_reg[i])) + 33'd32768) >> 16)
                : 35'((33'(a_reg[i]) + 33'd32768) >> 16));
        end
    end

    isi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .done  (div_done),
        .quot  (div_quot)
    );

    isi_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_NLERP;
            count_reg      <= '0;
            k_reg          <= '0;
            pend_reg       <= 1'b0;
            go_reg         <= 1'b0;
            hp_reg         <= 1'b0;
            hn_reg         <= 1'b0;
            lane_reg       <= '0;
            bit_reg        <= '0;
            status_reg     <= STAT_OK;
            src_reg        <= '0;
            tm_reg         <= '0;
            tp_reg         <= '0;
            tn_reg         <= '0;
            prev_reg       <= '0;
            next_reg       <= '0;
            t_reg          <= '0;
            dot_reg        <= '0;
            s_reg          <= '0;
            len_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= STAT_OK;
            for (int i = 0; i < 4; i++)
            begin
                p_reg[i]     <= '0;
                n_reg[i]     <= '0;
                r_reg[i]     <= '0;
                a_reg[i]     <= '0;
                b_reg[i]     <= '0;
                q_out_reg[i] <= '0;
                rsp_q_reg[i] <= '0;
            end
            for (int i = 0; i < 6; i++)
            begin
                smp_out_reg[i] <= '0;
                rsp_smp_reg[i] <= '0;
            end
        end
        else
        begin
            if (rsp.ready && (state_reg != ST_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        src_reg    <= src_ext[SOURCE_BITS-1:0];
                        tm_reg     <= req.time_us;
                        k_reg      <= '0;
                        pend_reg   <= 1'b0;
                        hp_reg     <= 1'b0;
                        hn_reg     <= 1'b0;
                        go_reg     <= 1'b0;
                        for (int i = 0; i < 4; i++)
                        begin
                            q_out_reg[i] <= '0;
                        end
                        for (int i = 0; i < 6; i++)
                        begin
                            smp_out_reg[i] <= '0;
                        end
                        case (req.action)
                            ACT_APPEND:
                            begin
                                if (full)
                                begin
                                    status_reg <= STAT_FULL;
                                end
                                else
                                begin
                                    status_reg <= STAT_OK;
                                    count_reg  <= count_reg + CW'(1);
                                end
                                state_reg <= ST_DONE;
                            end
                            ACT_QUERY:
                            begin
                                status_reg <= STAT_OK;
                                state_reg  <= ST_SCAN;
                            end
                            ACT_CLEAR:
                            begin
                                status_reg <= STAT_OK;
                                count_reg  <= '0;
                                state_reg  <= ST_DONE;
                            end
                            default:
                            begin
                                status_reg <= STAT_OK;
                                state_reg  <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (rd_en)
                    begin
                        k_reg <= k_reg + CW'(1);
                    end
                    pend_reg <= rd_en;
                    if (pend_reg && (rd_src == src_reg))
                    begin
                        if (rd_time <= tm_reg)
                        begin
                            if (!hp_reg || (rd_time > tp_reg))
                            begin
                                hp_reg   <= 1'b1;
                                tp_reg   <= rd_time;
                                prev_reg <= rd_data;
                            end
                        end
                        else if (!hn_reg || (rd_time < tn_reg))
                        begin
                            hn_reg   <= 1'b1;
                            tn_reg   <= rd_time;
                            next_reg <= rd_data;
                        end
                    end
                    if (!pend_reg && (k_reg == count_reg))
                    begin
                        if (hp_reg && hn_reg)
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                p_reg[i] <= $signed(prev_reg[(3 - i) * 16 +: 16]);
                                n_reg[i] <= 17'($signed(next_reg[(3 - i) * 16 +: 16]));
                            end
                            state_reg <= ST_TDIV;
                        end
                        else
                        begin
                            status_reg <= STAT_NO_BRACKET;
                            state_reg  <= ST_DONE;
                        end
                    end
                end
                ST_TDIV:
                begin
                    if (!go_reg)
                    begin
                        go_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        go_reg    <= 1'b0;
                        t_reg     <= div_quot[15:0];
                        lane_reg  <= '0;
                        state_reg <= ST_LERP;
                    end
                end
                ST_LERP:
                begin
                    if (lane_reg < 4'd6)
                    begin
                        smp_out_reg[lane_reg[2:0]] <= 16'(lres[OW-1:0]);
                    end
                    else
                    begin
                        r_reg[qlane] <= 17'(lres);
                    end
                    if (lane_reg == 4'd5)
                    begin
                        lane_reg  <= '0;
                        dot_reg   <= '0;
                        state_reg <= ST_DOT;
                    end
                    else if (lane_reg == 4'd9)
                    begin
                        lane_reg  <= '0;
                        s_reg     <= '0;
                        state_reg <= ST_SQ;
                    end
                    else
                    begin
                        lane_reg <= lane_reg + 4'd1;
                    end
                end
                ST_DOT:
                begin
                    dot_reg  <= dot_reg + dprod;
                    lane_reg <= lane_reg + 4'd1;
                    if (lane_reg == 4'd3)
                    begin
                        state_reg <= ST_FLIP;
                    end
                end
                ST_FLIP:
                begin
                    if (dot_reg[33])
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            n_reg[i] <= -n_reg[i];
                        end
                    end
                    if (absdot > $signed(DOT_LIMIT))
                    begin
                        phase_reg <= PH_NLERP;
                        lane_reg  <= 4'd6;
                        state_reg <= ST_LERP;
                    end
                    else
                    begin
                        phase_reg <= PH_UNIT_P;
                        lane_reg  <= '0;
                        s_reg     <= '0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    s_reg    <= s_reg + vsq;
                    lane_reg <= lane_reg + 4'd1;
                    if (lane_reg == 4'd3)
                    begin
                        go_reg    <= 1'b0;
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (!go_reg)
                    begin
                        go_reg <= 1'b1;
                    end
                    else if (sq_done)
                    begin
                        go_reg   <= 1'b0;
                        len_reg  <= sq_root;
                        lane_reg <= '0;
                        if (sq_root == '0)
                        begin
                            state_reg <= (phase_reg == PH_BISECT) ? ST_NEXT : ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_NDIV;
                        end
                    end
                end
                ST_NDIV:
                begin
                    if (!go_reg)
                    begin
                        go_reg <= 1'b1;
                    end
                    else if (div_done)
                    begin
                        go_reg <= 1'b0;
                        case (phase_reg)
                            PH_NLERP:  q_out_reg[vlane] <= clamp_q14(qs);
                            PH_UNIT_P: a_reg[vlane] <= 32'(qs);
                            PH_UNIT_N: b_reg[vlane] <= 32'(qs);
                            PH_BISECT:
                            begin
                                if (t_reg[bit_reg])
                                begin
                                    a_reg[vlane] <= 32'(qs);
                                end
                                else
                                begin
                                    b_reg[vlane] <= 32'(qs);
                                end
                            end
                            default:   len_reg <= len_reg;
                        endcase
                        lane_reg <= lane_reg + 4'd1;
                        if (lane_reg == 4'd3)
                        begin
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                ST_NEXT:
                begin
                    lane_reg <= '0;
                    s_reg    <= '0;
                    case (phase_reg)
                        PH_NLERP:
                        begin
                            state_reg <= ST_DONE;
                        end
                        PH_UNIT_P:
                        begin
                            phase_reg <= PH_UNIT_N;
                            state_reg <= ST_SQ;
                        end
                        PH_UNIT_N:
                        begin
                            phase_reg <= PH_BISECT;
                            bit_reg   <= 4'd15;
                            state_reg <= ST_SQ;
                        end
                        default:
                        begin
                            if (bit_reg == 4'd0)
                            begin
                                state_reg <= ST_FINAL;
                            end
                            else
                            begin
                                bit_reg   <= bit_reg - 4'd1;
                                state_reg <= ST_SQ;
                            end
                        end
                    endcase
                end
                ST_FINAL:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        q_out_reg[i] <= fin_q[i];
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= status_reg;
                        for (int i = 0; i < 6; i++)
                        begin
                            rsp_smp_reg[i] <= smp_out_reg[i];
                        end
                        for (int i = 0; i < 4; i++)
                        begin
                            rsp_q_reg[i] <= q_out_reg[i];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.out_accel_x = $signed(rsp_smp_reg[0]);
    assign rsp.out_accel_y = $signed(rsp_smp_reg[1]);
    assign rsp.out_accel_z = $signed(rsp_smp_reg[2]);
    assign rsp.out_gyro_x  = $signed(rsp_smp_reg[3]);
    assign rsp.out_gyro_y  = $signed(rsp_smp_reg[4]);
    assign rsp.out_gyro_z  = $signed(rsp_smp_reg[5]);
    assign rsp.out_quat_w  = rsp_q_reg[0];
    assign rsp.out_quat_x  = rsp_q_reg[1];
    assign rsp.out_quat_y  = rsp_q_reg[2];
    assign rsp.out_quat_z  = rsp_q_reg[3];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(WINDOW_DEPTH))
        else $error("window count beyond depth");

    a_count_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(accept) && ($past(req.action) == ACT_APPEND
                || $past(req.action) == ACT_CLEAR)))
        else $error("window count changed without append or clear");

    a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TDIV) |-> (hp_reg && hn_reg && tp_reg <= tm_reg
            && tm_reg < tn_reg))
        else $error("interpolation started without bracketing samples");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && status_reg == STAT_FULL) |-> full)
        else $error("store full reported with room left");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result presented outside completion");
endmodule
